[rtl/core/dmx512_frame_receiver_macros.svh]
// assertion macros for the dmx512 frame receiver checker
// depends on nothing; taken in by the checker file
`ifndef DMX512_FRAME_RECEIVER_MACROS_SVH
`define DMX512_FRAME_RECEIVER_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define DMXR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define DMXR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/dmxr_pkg.sv]
// shared types and constants for the dmx512 frame receiver
// depends on nothing
package dmxr_pkg;

   localparam int OP_W      = 3;
   localparam int BYTE_W    = 8;
   localparam int CH_W      = 16;
   localparam int TIMEOUT_W = 16;
   localparam int ELAPSED_W = 16;
   localparam int LINK_W    = 2;

   localparam int DMXR_CHANNELS = 512;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

   localparam logic [OP_W-1:0] OP_BYTE  = 3'd0;
   localparam logic [OP_W-1:0] OP_BREAK = 3'd1;
   localparam logic [OP_W-1:0] OP_ERROR = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ  = 3'd4;

   localparam logic [LINK_W-1:0] LINK_IDLE  = 2'd0;
   localparam logic [LINK_W-1:0] LINK_BREAK = 2'd1;
   localparam logic [LINK_W-1:0] LINK_DATA  = 2'd2;

   // per-item status handed from the controller to the output pipeline
   typedef struct packed {
      logic              read_hit;
      logic              healthy;
      logic [LINK_W-1:0] link_state;
   } dmxr_status_type;

endpackage

[rtl/core/dmx512_frame_receiver.sv]
// dmx512 frame receiver usage notes
// one event per transfer on req_: operation selects data byte, break, line
// error, tick or channel read; rx_byte and channel go with it. every request
// gives exactly one response on rsp_: read_value (slot value for a read,
// zero otherwise), healthy and link_state as seen after the event.
// csr_write_enable with csr_write_data loads the timeout register.
// each response passes the read stage, where the slot ram read is registered,
// and then the output register before it is offered on rsp_.
// throughput: one request per cycle unless rsp_ready stalls; the single
// ram port pair suffices (a write for a byte, a read for a channel read).
// reset: receive state idle, counters zero, timeout 500, and the slot store
// reads as all zeros at once, through a fill count that masks never
// written slots, so no clearing pass is needed.
// stalls: a low rsp_ready keeps the response stable; one more request is
// taken into the read stage, then req_ready drops until space frees up.
module dmx512_frame_receiver
   import dmxr_pkg::*;
#(
   parameter int CHANNELS = DMXR_CHANNELS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   input  logic [CH_W-1:0]      req_channel,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_read_value,
   output logic                 rsp_healthy,
   output logic [LINK_W-1:0]    rsp_link_state,
   input  logic                 csr_write_enable,
   input  logic [TIMEOUT_W-1:0] csr_write_data
);

   localparam int ADDR_W = $clog2(CHANNELS + 1);

   logic                  accept;
   dmxr_status_type       status;
   logic                  mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]     mem_wr_addr, mem_rd_addr;
   logic [BYTE_W-1:0]     mem_wr_data, mem_rd_data;

   // read stage: waits on the ram read data
   logic                  s1_valid_ff, s1_valid_in;
   dmxr_status_type       s1_status_ff;
   logic                  s1_move;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_read_value_ff;
   logic                  rsp_healthy_ff;
   logic [LINK_W-1:0]     rsp_link_state_ff;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   dmxr_ctrl #(
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .operation        (req_operation),
      .rx_byte          (req_rx_byte),
      .channel          (req_channel),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr)
   );

   // read data holds while the read stage stalls, as no new read is issued
   dmxr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CHANNELS + 1)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      s1_valid_in = accept || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_status_ff <= status;
      end
      if (s1_move) begin
         rsp_read_value_ff <= s1_status_ff.read_hit ? mem_rd_data : '0;
         rsp_healthy_ff    <= s1_status_ff.healthy;
         rsp_link_state_ff <= s1_status_ff.link_state;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_healthy    = rsp_healthy_ff;
   assign rsp_link_state = rsp_link_state_ff;

endmodule

[rtl/core/dmxr_ram.sv]
// generic single write port, single read port ram with registered read
// depends on nothing
module dmxr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 513
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/dmxr_ctrl.sv]
// receive state, slot index, tick counter, fill count and timeout register
// depends on dmxr_pkg; drives the slot ram ports
module dmxr_ctrl
   import dmxr_pkg::*;
#(
   parameter int CHANNELS = DMXR_CHANNELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [OP_W-1:0]               operation,
   input  logic [BYTE_W-1:0]             rx_byte,
   input  logic [CH_W-1:0]               channel,
   input  logic                          csr_write_enable,
   input  logic [TIMEOUT_W-1:0]          csr_write_data,
   output dmxr_status_type               status,
   output logic                          mem_wr_en,
   output logic [$clog2(CHANNELS+1)-1:0] mem_wr_addr,
   output logic [BYTE_W-1:0]             mem_wr_data,
   output logic                          mem_rd_en,
   output logic [$clog2(CHANNELS+1)-1:0] mem_rd_addr
);

   localparam int SLOT_COUNT = CHANNELS + 1;
   localparam int ADDR_W     = $clog2(SLOT_COUNT);
   localparam int IDX_W      = $clog2(SLOT_COUNT + 1);

   typedef enum logic [LINK_W-1:0] {
      ST_IDLE  = LINK_IDLE,
      ST_BREAK = LINK_BREAK,
      ST_DATA  = LINK_DATA
   } rx_state_type;

   rx_state_type           state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in, idx_cur;
   logic [IDX_W-1:0]       fill_ff, fill_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic [TIMEOUT_W-1:0]   timeout_ff;

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      idx_cur         = idx_ff;
      fill_in         = fill_ff;
      elapsed_in      = elapsed_ff;
      mem_wr_en       = 1'b0;
      mem_rd_en       = 1'b0;
      status.read_hit = 1'b0;
      if (accept) begin
         case (operation)
            OP_BYTE: begin
               // zero start code after a break opens a frame
               if (state_ff == ST_BREAK && rx_byte == '0) begin
                  state_in   = ST_DATA;
                  idx_cur    = '0;
                  elapsed_in = '0;
               end
               if (state_in == ST_DATA && idx_cur < IDX_W'(SLOT_COUNT)) begin
                  mem_wr_en = 1'b1;
                  idx_in    = idx_cur + 1'b1;
                  if (idx_cur >= fill_ff) begin
                     fill_in = idx_cur + 1'b1;
                  end
               end
            end
            OP_BREAK: begin
               state_in = ST_BREAK;
            end
            OP_TICK: begin
               if (elapsed_ff != '1) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            OP_READ: begin
               mem_rd_en = 1'b1;
               // slots never written read as zero through the fill count mask
               status.read_hit = (channel != '0) && (channel <= CH_W'(CHANNELS))
                                 && (channel < CH_W'(fill_ff));
            end
            OP_ERROR: begin
               state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
      status.healthy    = elapsed_in < timeout_ff;
      status.link_state = state_in;
   end

   assign mem_wr_addr = idx_cur[ADDR_W-1:0];
   assign mem_wr_data = rx_byte;
   assign mem_rd_addr = channel[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         fill_ff    <= '0;
         elapsed_ff <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         fill_ff    <= fill_in;
         elapsed_ff <= elapsed_in;
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
      end
   end

endmodule

[rtl/core/dmxr_checker.sv]
// port-level checks for the dmx512 frame receiver, bound to the top level
// depends on dmxr_pkg and dmx512_frame_receiver_macros.svh
`include "dmx512_frame_receiver_macros.svh"

module dmxr_checker
   import dmxr_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [BYTE_W-1:0]    rsp_read_value,
   input logic                 rsp_healthy,
   input logic [LINK_W-1:0]    rsp_link_state
);

   // requests taken but not yet answered
   logic [2:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `DMXR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_healthy) && $stable(rsp_link_state), "response changed while stalled")
   `DMXR_ASSERT(a_rsp_needs_req, clock, reset, !rsp_valid || pending_ff != 3'd0, "response without a pending request")
   `DMXR_ASSERT(a_pending_bound, clock, reset, pending_ff <= 3'd2, "more than two requests in flight")
   `DMXR_ASSERT(a_link_code, clock, reset, !rsp_valid || rsp_link_state != 2'd3, "response carries an unused link state")
   `DMXR_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid, "response offered straight after reset")

endmodule

bind dmx512_frame_receiver dmxr_checker u_dmxr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_healthy    (rsp_healthy),
   .rsp_link_state (rsp_link_state)
);

[sim/tb_dmx512_frame_receiver.sv]
// self-checking testbench for the dmx512 frame receiver: random and directed events,
// predicted responses compared field by field in transfer order
// depends on dmxr_pkg and dmx512_frame_receiver
module tb_dmx512_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;
   import dmxr_pkg::*;

   // slot 0 holds the start code, slots 1 to 512 the channels
   localparam int SLOT_COUNT  = DMXR_CHANNELS + 1;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 4;
   localparam int TICK_RUN    = 16;

   localparam logic [OP_W-1:0]      OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0]      OP_UNUSED_MID   = 3'd6;
   localparam logic [OP_W-1:0]      OP_UNUSED_LAST  = 3'd7;
   localparam logic [BYTE_W-1:0]    START_CODE      = 8'h00;
   localparam logic [ELAPSED_W-1:0] TICK_CEILING    = 16'hFFFF;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX     = 16'hFFFF;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_ZERO    = 16'h0000;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] rx_byte;
      logic [CH_W-1:0]   channel;
   } dmx_event_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_value;
      logic              healthy;
      logic [LINK_W-1:0] link_state;
   } dmx_reply_type;

   // ports of the block, every input known from time zero
   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_operation    = '0;
   logic [BYTE_W-1:0]    req_rx_byte      = '0;
   logic [CH_W-1:0]      req_channel      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [BYTE_W-1:0]    rsp_read_value;
   logic                 rsp_healthy;
   logic [LINK_W-1:0]    rsp_link_state;
   logic                 csr_write_enable = 1'b0;
   logic [TIMEOUT_W-1:0] csr_write_data   = '0;

   dmx512_frame_receiver u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_rx_byte      (req_rx_byte),
      .req_channel      (req_channel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_value   (rsp_read_value),
      .rsp_healthy      (rsp_healthy),
      .rsp_link_state   (rsp_link_state),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // stimulus waiting for the driver, and responses predicted but not yet seen
   dmx_event_type pending_events[$];
   dmx_reply_type reply_q[$];

   // receiver state as the predictor sees it
   logic [LINK_W-1:0]    link_now;
   logic [9:0]           slot_ptr;
   logic [BYTE_W-1:0]    slot_mem [0:SLOT_COUNT-1];
   logic [ELAPSED_W-1:0] tick_count;
   logic [TIMEOUT_W-1:0] timeout_cfg;

   // idling limits, changed between phases
   int unsigned send_gap_max = 0;
   int unsigned stall_max    = 0;

   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   int unsigned hold_left = 0;
   logic        hold_kick = 1'b0;

   // run statistics
   int fault_count     = 0;
   int events_sent     = 0;
   int replies_checked = 0;
   int frames_begun    = 0;
   int bytes_dropped   = 0;
   int healthy_lows    = 0;
   int timeouts_loaded = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case a transfer never completes
   initial begin
      #(5_000_000);
      $display("simulation failed");
      $finish;
   end

   // advance the predicted state by one event and return the response it gives
   function automatic dmx_reply_type dmx_apply_event(dmx_event_type ev);
      dmx_reply_type r;
      r.read_value = '0;
      case (ev.operation)
         OP_BYTE: begin
            // a zero byte straight after a break opens a new frame
            if (link_now == LINK_BREAK && ev.rx_byte == START_CODE) begin
               link_now   = LINK_DATA;
               slot_ptr   = '0;
               tick_count = '0;
               frames_begun++;
            end
            if (link_now == LINK_DATA) begin
               if (slot_ptr < SLOT_COUNT) begin
                  slot_mem[slot_ptr] = ev.rx_byte;
                  slot_ptr = slot_ptr + 1'b1;
               end else begin
                  bytes_dropped++;
               end
            end
         end
         OP_BREAK: link_now = LINK_BREAK;
         OP_TICK: begin
            if (tick_count != TICK_CEILING) tick_count = tick_count + 1'b1;
         end
         OP_READ: begin
            if (ev.channel >= 1 && ev.channel <= DMXR_CHANNELS)
               r.read_value = slot_mem[ev.channel];
         end
         // line error and the unused codes all drop back to idle
         default: link_now = LINK_IDLE;
      endcase
      r.healthy    = (tick_count < timeout_cfg);
      r.link_state = link_now;
      return r;
   endfunction

   function automatic void queue_event(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                       logic [CH_W-1:0] ch);
      dmx_event_type ev;
      ev.operation = op;
      ev.rx_byte   = data;
      ev.channel   = ch;
      pending_events.push_back(ev);
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom);
   endfunction

   function automatic logic [CH_W-1:0] rand_chan();
      return CH_W'($urandom);
   endfunction

   // mostly well-formed frames with random content, plus tick/read runs and noise
   task automatic queue_random_traffic(input int n_events);
      int target;
      int len;
      int i;
      int pick;
      target = pending_events.size() + n_events;
      while (pending_events.size() < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 13) begin
            queue_event(OP_BREAK, rand_byte(), rand_chan());
            // sometimes a non-zero start code first, which must be skipped
            if ($urandom_range(0, 4) == 0)
               queue_event(OP_BYTE, BYTE_W'($urandom_range(1, 255)), rand_chan());
            queue_event(OP_BYTE, START_CODE, rand_chan());
            len = $urandom_range(1, 24);
            for (i = 0; i < len; i++) begin
               pick = $urandom_range(0, 9);
               if (pick < 6)
                  queue_event(OP_BYTE, rand_byte(), rand_chan());
               else if (pick < 8)
                  queue_event(OP_TICK, rand_byte(), rand_chan());
               else
                  queue_event(OP_READ, rand_byte(), CH_W'($urandom_range(0, len + 2)));
            end
            // a frame broken off by a line error now and then
            if ($urandom_range(0, 5) == 0) queue_event(OP_ERROR, rand_byte(), rand_chan());
         end else if (pick < 17) begin
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
               pick = $urandom_range(0, 3);
               if (pick < 2)
                  queue_event(OP_TICK, rand_byte(), rand_chan());
               else if (pick == 2)
                  queue_event(OP_READ, rand_byte(), CH_W'($urandom_range(0, SLOT_COUNT)));
               else
                  queue_event(OP_READ, rand_byte(), rand_chan());
            end
         end else begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
               queue_event(OP_W'($urandom_range(0, 7)), rand_byte(), rand_chan());
         end
      end
   endtask

   // nothing left to send, nothing on the request port and no response outstanding;
   // sampled on the falling edge so the clocked processes have settled
   task automatic wait_until_quiet();
      while (pending_events.size() != 0 || req_valid || reply_q.size() != 0)
         @(negedge clock);
   endtask

   // register load, only ever done with the block idle
   task automatic load_timeout(input logic [TIMEOUT_W-1:0] value);
      wait_until_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      timeout_cfg = value;
      timeouts_loaded++;
   endtask

   task automatic set_idling(input int unsigned send_max, input int unsigned recv_max);
      wait_until_quiet();
      send_gap_max = send_max;
      stall_max    = recv_max;
   endtask

   // request driver: takes the next pending event after a drawn gap and keeps
   // valid and payload steady until the transfer happens
   always @(posedge clock) begin : drive_proc
      dmx_event_type nxt;
      dmx_event_type sent;
      int unsigned gap;
      logic offering;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         gap      = send_wait;
         offering = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            // transfer taken, so predict its response now
            sent.operation = req_operation;
            sent.rx_byte   = req_rx_byte;
            sent.channel   = req_channel;
            reply_q.push_back(dmx_apply_event(sent));
            events_sent++;
            gap = $urandom_range(0, send_gap_max);
         end else if (!req_valid && gap != 0) begin
            gap = gap - 1;
         end
         if (!offering && gap == 0 && pending_events.size() != 0) begin
            nxt = pending_events.pop_front();
            req_operation <= nxt.operation;
            req_rx_byte   <= nxt.rx_byte;
            req_channel   <= nxt.channel;
            req_valid     <= 1'b1;
         end else if (!offering) begin
            req_valid <= 1'b0;
         end
         send_wait <= gap;
      end
   end

   // long receiver hold-off, counted here on its own
   always @(posedge clock) begin
      if (hold_kick && hold_left == 0)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // response monitor: compares each transfer with the oldest prediction, then
   // draws a random stall before the next one
   always @(posedge clock) begin : check_proc
      dmx_reply_type want;
      int unsigned wait_n;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else begin
         wait_n = (recv_wait != 0) ? recv_wait - 1 : 0;
         if (rsp_valid && rsp_ready) begin
            if (reply_q.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: response with none predicted: value %0h healthy %0b link %0d",
                           $realtime, rsp_read_value, rsp_healthy, rsp_link_state);
            end else begin
               want = reply_q.pop_front();
               replies_checked++;
               if (!want.healthy) healthy_lows++;
               if (rsp_read_value !== want.read_value || rsp_healthy !== want.healthy ||
                   rsp_link_state !== want.link_state) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $write("%0t: response %0d mismatch: value %0h/%0h healthy %0b/%0b",
                            $realtime, replies_checked, want.read_value, rsp_read_value,
                            want.healthy, rsp_healthy);
                     $display(" link %0d/%0d (expected/actual)",
                              want.link_state, rsp_link_state);
                  end
               end
            end
            wait_n = $urandom_range(0, stall_max);
         end
         recv_wait <= wait_n;
         rsp_ready <= (wait_n == 0) && (hold_left == 0);
      end
   end

   initial begin : stimulus_proc
      int i;
      // predictor starts from the reset state, timeout at its reset value
      link_now    = LINK_IDLE;
      slot_ptr    = '0;
      tick_count  = '0;
      timeout_cfg = TIMEOUT_RESET;
      for (i = 0; i < SLOT_COUNT; i++) slot_mem[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset timeout, field extremes, every operation and the corner cases
      set_idling(3, 3);
      queue_event(OP_READ, 8'hFF, 16'd1);              // store reads zero after reset
      queue_event(OP_BYTE, 8'h55, 16'hFFFF);           // byte while idle is ignored
      queue_event(OP_TICK, 8'hFF, 16'hFFFF);
      queue_event(OP_READ, 8'h00, 16'd0);              // channel zero is out of range
      queue_event(OP_BREAK, 8'hFF, 16'h0000);
      queue_event(OP_BYTE, 8'hA5, 16'h0000);           // non-zero start code keeps waiting
      queue_event(OP_BYTE, START_CODE, 16'hFFFF);      // frame opens here
      queue_event(OP_BYTE, 8'hFF, 16'h0000);
      queue_event(OP_BYTE, 8'h80, 16'h0000);
      queue_event(OP_BYTE, 8'h01, 16'h0000);
      queue_event(OP_READ, 8'h00, 16'd1);
      queue_event(OP_READ, 8'h00, 16'd3);
      queue_event(OP_READ, 8'h00, CH_W'(DMXR_CHANNELS)); // last real channel
      queue_event(OP_READ, 8'h00, CH_W'(SLOT_COUNT));    // one past it
      queue_event(OP_READ, 8'hFF, 16'hFFFF);
      queue_event(OP_TICK, 8'h00, 16'h0000);
      queue_event(OP_ERROR, 8'hFF, 16'hFFFF);          // line error drops to idle
      queue_event(OP_BYTE, 8'h7E, 16'h0000);
      queue_event(OP_BREAK, 8'h00, 16'h0000);
      queue_event(OP_UNUSED_FIRST, 8'h00, 16'h0000);   // unused codes act as a line error
      queue_event(OP_BREAK, 8'h00, 16'h0000);
      queue_event(OP_UNUSED_MID, 8'hFF, 16'hFFFF);
      queue_event(OP_UNUSED_LAST, 8'h00, 16'h0000);
      queue_event(OP_READ, 8'h00, 16'd2);

      // timeout of one, heavy idling on both sides
      load_timeout(16'd1);
      set_idling(19, 19);
      queue_random_traffic(30);

      // zero timeout, link never healthy
      load_timeout(TIMEOUT_ZERO);
      set_idling(19, 0);
      queue_random_traffic(15);

      // small timeouts so health flips often, idling patterns varied per phase
      for (i = 0; i < 4; i++) begin
         load_timeout(TIMEOUT_W'($urandom_range(2, 40)));
         case (i)
            0: set_idling(0, 0);
            1: set_idling(0, 19);
            2: set_idling(19, 19);
            default: set_idling(5, 2);
         endcase
         queue_random_traffic(25);
      end

      // receiver holds off while the sender keeps offering, so the block backs up
      load_timeout(16'd8);
      set_idling(0, 0);
      queue_random_traffic(25);
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;

      // one frame long enough to fill the store and run past its end
      load_timeout(16'd3);
      set_idling(2, 2);
      queue_event(OP_BREAK, rand_byte(), rand_chan());
      queue_event(OP_BYTE, START_CODE, rand_chan());
      for (i = 0; i < SLOT_COUNT + 8; i++) queue_event(OP_BYTE, rand_byte(), rand_chan());
      queue_event(OP_READ, rand_byte(), 16'd1);
      queue_event(OP_READ, rand_byte(), CH_W'(DMXR_CHANNELS));
      queue_event(OP_READ, rand_byte(), CH_W'(SLOT_COUNT));

      // largest timeout, a short tick run, then a new frame clears the count
      load_timeout(TIMEOUT_MAX);
      set_idling(0, 0);
      queue_event(OP_BREAK, rand_byte(), rand_chan());
      queue_event(OP_BYTE, START_CODE, rand_chan());
      for (i = 0; i < TICK_RUN; i++) queue_event(OP_TICK, rand_byte(), rand_chan());
      queue_event(OP_READ, rand_byte(), 16'd1);
      queue_event(OP_BREAK, rand_byte(), rand_chan());
      queue_event(OP_BYTE, START_CODE, rand_chan());   // new frame clears the count

      // closing mix at a random timeout
      load_timeout(TIMEOUT_W'($urandom_range(1, 65535)));
      set_idling(19, 19);
      queue_random_traffic(25);

      wait_until_quiet();
      repeat (8) @(posedge clock);

      $display("run covered %0d events and %0d checked responses, %0d frames opened",
               events_sent, replies_checked, frames_begun);
      $display("%0d bytes past the store end, %0d unhealthy responses, %0d timeout loads",
               bytes_dropped, healthy_lows, timeouts_loaded);
      if (fault_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d faults in total", fault_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
